// File: hw/rtl/pixel_mask_collision_normal_bounce_core_defines.svh
// Assertion macros for the collision normal and bounce core
`ifndef PIXEL_MASK_COLLISION_NORMAL_BOUNCE_CORE_DEFINES_SVH
`define PIXEL_MASK_COLLISION_NORMAL_BOUNCE_CORE_DEFINES_SVH
// check an implication on every clock edge outside reset
`define PMC_ASSERT_IMP(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);
// check an implication in the cycle after the condition
`define PMC_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`endif

// File: hw/rtl/pmc_pkg.sv
// Shared constants and normal lookup for the collision normal core
`default_nettype none
package pmc_pkg;
   localparam int VEL_WIDTH_DEF   = 32;
   localparam int NORMAL_FRAC_DEF = 14;
   localparam int COORD_WIDTH_DEF = 12;
   localparam int CSR_WIDTH       = 13;
   localparam logic [CSR_WIDTH-1:0] MASK_RESET = 13'd4096;
   localparam logic CSR_MASK_WIDTH  = 1'b0;
   localparam logic CSR_MASK_HEIGHT = 1'b1;
   localparam longint Q30_ONE  = 64'sd1073741824;
   localparam longint Q30_RT2  = 64'sd759250125;
   localparam longint Q30_2RT5 = 64'sd960383883;
   localparam longint Q30_1RT5 = 64'sd480191942;

   // magnitude class of a unit component
   localparam logic [2:0] CLS_ZERO = 3'd0;
   localparam logic [2:0] CLS_ONE  = 3'd1;
   localparam logic [2:0] CLS_RT2  = 3'd2;
   localparam logic [2:0] CLS_2RT5 = 3'd3;
   localparam logic [2:0] CLS_1RT5 = 3'd4;

   typedef struct packed {
      logic [2:0] cls_x;
      logic       neg_x;
      logic [2:0] cls_y;
      logic       neg_y;
   } norm_code_type;

   function automatic logic [2:0] comp_class(input int c, input int o);
      int ac;
      int ao;
      ac = (c < 0) ? -c : c;
      ao = (o < 0) ? -o : o;
      if (c == 0) return CLS_ZERO;
      else if (ao == 0) return CLS_ONE;
      else if (ac == ao) return CLS_RT2;
      else if (ac > ao) return CLS_2RT5;
      else return CLS_1RT5;
   endfunction

   // priority rules on the permuted neighbor bits
   function automatic norm_code_type rule_normal(input logic [7:0] m);
      int x;
      int y;
      norm_code_type r;
      x = -1; y = 0;
      if (m[0]) begin
         if (m[5]) begin x = -1; y = 0; end
         else if (m[6]) begin x = -2; y = 1; end
         else if (m[3]) begin x = -1; y = 0; end
         else if (m[4]) begin x = -2; y = -1; end
         else begin x = -1; y = 1; end
      end else if (m[3]) begin
         if (m[1]) begin x = -1; y = -1; end
         else if (m[2]) begin x = -1; y = -2; end
         else if (m[4]) begin x = 0; y = -1; end
         else if (m[7]) begin x = 1; y = -2; end
         else if (m[6]) begin x = -1; y = 1; end
         else begin x = -1; y = 0; end
      end else if (m[5]) begin
         if (m[1]) begin x = -2; y = -1; end
         else if (m[2]) begin x = -1; y = -1; end
         else if (m[4]) begin x = -1; y = -2; end
         else if (m[7]) begin x = 0; y = -1; end
         else begin x = -1; y = -1; end
      end else if (m[1]) begin
         if (m[6]) begin x = -1; y = 0; end
         else if (m[7]) begin x = -2; y = 1; end
         else begin x = -1; y = 0; end
      end else if (m[2]) begin
         if (m[6]) begin x = -2; y = -1; end
         else begin x = -1; y = 1; end
      end else if (m[6]) begin
         x = -1; y = -1;
      end
      r.cls_x = comp_class(x, y);
      r.neg_x = (x < 0);
      r.cls_y = comp_class(y, x);
      r.neg_y = (y < 0);
      return r;
   endfunction
endpackage
`default_nettype wire

// File: hw/rtl/pmc_normal.sv
// Neighbor masking, octant selection and normal lookup (two register stages)
`default_nettype none
module pmc_normal #(
   parameter int NORMAL_FRAC = pmc_pkg::NORMAL_FRAC_DEF,
   parameter int COORD_WIDTH = pmc_pkg::COORD_WIDTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          enable,
   input  wire logic [7:0]                    neighbor_bits,
   input  wire logic [COORD_WIDTH-1:0]        point_x,
   input  wire logic [COORD_WIDTH-1:0]        point_y,
   input  wire logic signed [31:0]            entry_x,
   input  wire logic signed [31:0]            entry_y,
   input  wire logic [pmc_pkg::CSR_WIDTH-1:0] mask_width,
   input  wire logic [pmc_pkg::CSR_WIDTH-1:0] mask_height,
   output logic signed [NORMAL_FRAC+1:0]      normal_x,
   output logic signed [NORMAL_FRAC+1:0]      normal_y
);
   localparam int NW = NORMAL_FRAC + 2;
   localparam int SH = 30 - NORMAL_FRAC;
   localparam longint RND = 64'sd1 <<< (SH - 1);
   localparam logic signed [NW-1:0] M_ONE  = NW'((pmc_pkg::Q30_ONE + RND) >>> SH);
   localparam logic signed [NW-1:0] M_RT2  = NW'((pmc_pkg::Q30_RT2 + RND) >>> SH);
   localparam logic signed [NW-1:0] M_2RT5 = NW'((pmc_pkg::Q30_2RT5 + RND) >>> SH);
   localparam logic signed [NW-1:0] M_1RT5 = NW'((pmc_pkg::Q30_1RT5 + RND) >>> SH);
   localparam int CW = (COORD_WIDTH + 1 > pmc_pkg::CSR_WIDTH) ?
                       COORD_WIDTH + 1 : pmc_pkg::CSR_WIDTH;

   // octant code: bit0 rightward, bit1 downward, bit2 steep
   typedef enum logic [2:0] {
      FLAT_LU = 3'd0, FLAT_RU = 3'd1, FLAT_LD = 3'd2, FLAT_RD = 3'd3,
      STEEP_LU = 3'd4, STEEP_RU = 3'd5, STEEP_LD = 3'd6, STEEP_RD = 3'd7
   } octant_type;

   logic [7:0] nb_in, nb_ff, pm;
   octant_type dir_in, dir_ff;
   logic [CW-1:0] px1, py1;
   logic [32:0] ax, ay;
   pmc_pkg::norm_code_type code;
   logic signed [NW-1:0] ux, uy, nx_in, ny_in;

   function automatic logic signed [NW-1:0] mag(input logic [2:0] c, input logic n);
      logic signed [NW-1:0] v;
      case (c)
         pmc_pkg::CLS_ONE:  v = M_ONE;
         pmc_pkg::CLS_RT2:  v = M_RT2;
         pmc_pkg::CLS_2RT5: v = M_2RT5;
         pmc_pkg::CLS_1RT5: v = M_1RT5;
         default:           v = '0;
      endcase
      return n ? -v : v;
   endfunction

   // clear neighbors outside the mask, classify entry octant
   always_comb begin
      px1 = CW'(point_x) + CW'(1);
      py1 = CW'(point_y) + CW'(1);
      nb_in = neighbor_bits;
      if (point_x == '0) nb_in = nb_in & 8'hD6;
      if (point_y == '0) nb_in = nb_in & 8'hF8;
      if (px1 >= CW'(mask_width)) nb_in = nb_in & 8'h6B;
      if (py1 >= CW'(mask_height)) nb_in = nb_in & 8'h1F;
      ax = entry_x[31] ? 33'(-$signed({entry_x[31], entry_x})) : {1'b0, entry_x};
      ay = entry_y[31] ? 33'(-$signed({entry_y[31], entry_y})) : {1'b0, entry_y};
      dir_in = octant_type'({ay > ax, ~entry_y[31], ~entry_x[31]});
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         nb_ff  <= nb_in;
         dir_ff <= dir_in;
      end
   end

   // permute neighbor bits by octant, look up and orient the normal
   always_comb begin
      case (dir_ff)
         FLAT_RU:  pm = {nb_ff[2], nb_ff[1], nb_ff[0], nb_ff[4], nb_ff[3],
                         nb_ff[7], nb_ff[6], nb_ff[5]};
         FLAT_LD:  pm = {nb_ff[5], nb_ff[6], nb_ff[7], nb_ff[3], nb_ff[4],
                         nb_ff[0], nb_ff[1], nb_ff[2]};
         FLAT_LU:  pm = {nb_ff[0], nb_ff[1], nb_ff[2], nb_ff[3], nb_ff[4],
                         nb_ff[5], nb_ff[6], nb_ff[7]};
         STEEP_RD: pm = {nb_ff[7], nb_ff[4], nb_ff[2], nb_ff[6], nb_ff[1],
                         nb_ff[5], nb_ff[3], nb_ff[0]};
         STEEP_RU: pm = {nb_ff[2], nb_ff[4], nb_ff[7], nb_ff[1], nb_ff[6],
                         nb_ff[0], nb_ff[3], nb_ff[5]};
         STEEP_LD: pm = {nb_ff[5], nb_ff[3], nb_ff[0], nb_ff[6], nb_ff[1],
                         nb_ff[7], nb_ff[4], nb_ff[2]};
         STEEP_LU: pm = {nb_ff[0], nb_ff[3], nb_ff[5], nb_ff[1], nb_ff[6],
                         nb_ff[2], nb_ff[4], nb_ff[7]};
         default:  pm = nb_ff;
      endcase
      code = pmc_pkg::rule_normal(pm);
      ux = mag(code.cls_x, code.neg_x);
      uy = mag(code.cls_y, code.neg_y);
      case (dir_ff)
         FLAT_RD:  begin nx_in = ux;  ny_in = uy;  end
         FLAT_RU:  begin nx_in = ux;  ny_in = -uy; end
         FLAT_LD:  begin nx_in = -ux; ny_in = uy;  end
         FLAT_LU:  begin nx_in = -ux; ny_in = -uy; end
         STEEP_RD: begin nx_in = uy;  ny_in = ux;  end
         STEEP_RU: begin nx_in = uy;  ny_in = -ux; end
         STEEP_LD: begin nx_in = -uy; ny_in = ux;  end
         default:  begin nx_in = -uy; ny_in = -ux; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         normal_x <= nx_in;
         normal_y <= ny_in;
      end
   end
endmodule
`default_nettype wire

// File: hw/rtl/pixel_mask_collision_normal_bounce_core.sv
// Collision normal and bounce core: top level pipeline
//
// Use: present one probe per cycle on the req_ channel (valid/ready); one
// result word per probe leaves on the rsp_ channel in the same order.
// csr_we/csr_index/csr_data set mask width (index 0) and height (index 1);
// write them only while the pipeline is empty.
// Throughput: one word per cycle while no stall holds the pipeline, set by
// the fully pipelined datapath: normal lookup (2 stages), dot product (2),
// reflection product (2), bounce scale and saturation (2).
// Reset: synchronous, active high; clears all stage valid bits and sets
// both mask sizes to 4096.
// Stall: when rsp_ready is low and the last stage holds a word, the whole
// pipeline holds and req_ready drops; while that stage is empty the
// pipeline keeps moving.
`default_nettype none
`include "pixel_mask_collision_normal_bounce_core_defines.svh"
module pixel_mask_collision_normal_bounce_core #(
   parameter int VEL_WIDTH   = pmc_pkg::VEL_WIDTH_DEF,
   parameter int NORMAL_FRAC = pmc_pkg::NORMAL_FRAC_DEF,
   parameter int COORD_WIDTH = pmc_pkg::COORD_WIDTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [7:0]                    req_neighbor_bits,
   input  wire logic [COORD_WIDTH-1:0]        req_point_x,
   input  wire logic [COORD_WIDTH-1:0]        req_point_y,
   input  wire logic signed [31:0]            req_entry_x,
   input  wire logic signed [31:0]            req_entry_y,
   input  wire logic signed [31:0]            req_vel_x,
   input  wire logic signed [31:0]            req_vel_y,
   input  wire logic [15:0]                   req_bounce,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed [15:0]                 rsp_normal_x,
   output logic signed [15:0]                 rsp_normal_y,
   output logic [30:0]                        rsp_impact,
   output logic signed [31:0]                 rsp_new_vel_x,
   output logic signed [31:0]                 rsp_new_vel_y,
   input  wire logic                          csr_we,
   input  wire logic                          csr_index,
   input  wire logic [pmc_pkg::CSR_WIDTH-1:0] csr_data
);
   localparam int NW = NORMAL_FRAC + 2;
   localparam int DEPTH = 8;
   localparam int VB = (VEL_WIDTH > 32) ? 32 : VEL_WIDTH;
   localparam longint VMAX = (64'sd1 <<< (VB - 1)) - 64'sd1;
   localparam longint VMIN = -VMAX - 64'sd1;
   localparam longint NMAX = 64'sd32767;
   localparam longint NMIN = -64'sd32768;
   localparam int F = NORMAL_FRAC;

   logic [pmc_pkg::CSR_WIDTH-1:0] mask_width_ff, mask_height_ff;
   logic [DEPTH-1:0] valid_ff;
   logic advance;
   logic signed [NW-1:0] nx2, ny2;

   // velocity and bounce delay line alongside the normal stages
   logic signed [31:0] vx_ff [2], vy_ff [2];
   logic [15:0] bf_ff [6];
   logic signed [NW-1:0] nx_ff [5], ny_ff [5];

   // dot product stages
   logic signed [63:0] px_ff, py_ff;
   logic signed [31:0] vx3_ff, vy3_ff, vx4_ff, vy4_ff;
   logic signed [63:0] dot_ff;
   // reflection stages
   logic signed [63:0] tx_ff, ty_ff;
   logic signed [63:0] dot5_ff;
   logic signed [31:0] vx5_ff, vy5_ff;
   logic signed [63:0] rx_ff, ry_ff;
   logic [30:0] imp6_ff;
   // scale stages
   logic signed [63:0] sx_ff, sy_ff;
   logic [30:0] imp7_ff;
   logic signed [15:0] onx_ff, ony_ff;
   logic [30:0] oimp_ff;
   logic signed [31:0] ovx_ff, ovy_ff;

   logic signed [63:0] dot_in, tx_r, ty_r, rx_in, ry_in, sx_r, sy_r;

   function automatic logic signed [63:0] rshr(input logic signed [63:0] x, input int s);
      return (x + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic logic signed [63:0] clamp(input logic signed [63:0] v,
                                               input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   assign advance   = rsp_ready | ~valid_ff[DEPTH-1];
   assign req_ready = advance;
   assign rsp_valid = valid_ff[DEPTH-1];

   // hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_width_ff  <= pmc_pkg::MASK_RESET;
         mask_height_ff <= pmc_pkg::MASK_RESET;
      end else if (csr_we) begin
         if (csr_index == pmc_pkg::CSR_MASK_WIDTH) mask_width_ff <= csr_data;
         else mask_height_ff <= csr_data;
      end
   end

   // advance stage valid bits
   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else if (advance) valid_ff <= {valid_ff[DEPTH-2:0], req_valid};
   end

   pmc_normal #(.NORMAL_FRAC(NORMAL_FRAC), .COORD_WIDTH(COORD_WIDTH)) u_normal (
      .clock(clock), .enable(advance),
      .neighbor_bits(req_neighbor_bits), .point_x(req_point_x), .point_y(req_point_y),
      .entry_x(req_entry_x), .entry_y(req_entry_y),
      .mask_width(mask_width_ff), .mask_height(mask_height_ff),
      .normal_x(nx2), .normal_y(ny2)
   );

   always_comb begin
      dot_in = rshr(px_ff + py_ff, F);
      tx_r   = rshr(tx_ff, F - 1);
      ty_r   = rshr(ty_ff, F - 1);
      rx_in  = 64'(vx5_ff) - tx_r;
      ry_in  = 64'(vy5_ff) - ty_r;
      sx_r   = clamp(rshr(sx_ff, 14), VMIN, VMAX);
      sy_r   = clamp(rshr(sy_ff, 14), VMIN, VMAX);
   end

   // datapath stages, all held on stall
   always_ff @(posedge clock) begin
      if (advance) begin
         vx_ff[0] <= req_vel_x;  vx_ff[1] <= vx_ff[0];
         vy_ff[0] <= req_vel_y;  vy_ff[1] <= vy_ff[0];
         bf_ff[0] <= req_bounce;
         for (int i = 1; i < 6; i++) bf_ff[i] <= bf_ff[i-1];
         nx_ff[0] <= nx2; ny_ff[0] <= ny2;
         for (int i = 1; i < 5; i++) begin
            nx_ff[i] <= nx_ff[i-1];
            ny_ff[i] <= ny_ff[i-1];
         end
         // stage 3: products v*n
         px_ff  <= 64'(vx_ff[1]) * 64'(nx2);
         py_ff  <= 64'(vy_ff[1]) * 64'(ny2);
         vx3_ff <= vx_ff[1]; vy3_ff <= vy_ff[1];
         // stage 4: rounded dot
         dot_ff <= dot_in;
         vx4_ff <= vx3_ff; vy4_ff <= vy3_ff;
         // stage 5: n*dot
         tx_ff   <= 64'(nx_ff[1]) * dot_ff;
         ty_ff   <= 64'(ny_ff[1]) * dot_ff;
         dot5_ff <= dot_ff;
         vx5_ff  <= vx4_ff; vy5_ff <= vy4_ff;
         // stage 6: reflected velocity, impact
         rx_ff   <= rx_in; ry_ff <= ry_in;
         imp6_ff <= 31'(clamp(dot5_ff < 0 ? -dot5_ff : dot5_ff, 0, 64'sd2147483647));
         // stage 7: bounce product
         sx_ff   <= rx_ff * $signed({48'd0, bf_ff[5]});
         sy_ff   <= ry_ff * $signed({48'd0, bf_ff[5]});
         imp7_ff <= imp6_ff;
         // stage 8: round, saturate, output register
         ovx_ff  <= 32'(sx_r);
         ovy_ff  <= 32'(sy_r);
         oimp_ff <= imp7_ff;
         onx_ff  <= 16'(clamp(64'(nx_ff[4]), NMIN, NMAX));
         ony_ff  <= 16'(clamp(64'(ny_ff[4]), NMIN, NMAX));
      end
   end

   assign rsp_normal_x  = onx_ff;
   assign rsp_normal_y  = ony_ff;
   assign rsp_impact    = oimp_ff;
   assign rsp_new_vel_x = ovx_ff;
   assign rsp_new_vel_y = ovy_ff;

   `PMC_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_impact), "stalled word changed")
   `PMC_ASSERT_IMP(a_ready, clock, reset, !rsp_valid, req_ready, "ready low with empty output")
   `PMC_ASSERT_NEXT(a_fill, clock, reset, req_valid && req_ready, valid_ff[0], "accepted word lost")
endmodule
`default_nettype wire
